// ===== design/frf_pkg.sv =====
// Shared types and constants for the framebuffer rectangle fill engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package frf_pkg;

    // Sizing defaults and fixed widths
    localparam int MAX_COORD_DEF = 4096;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int PROD_W        = 28;   // y_pos (12) times line_pitch (16)
    localparam int XOFF_W        = 14;   // x_pos (12) times 3 or 4
    localparam int JOB_FIXED_W   = 1 + PROD_W + XOFF_W + 32;

    // Command codes
    typedef enum logic [1:0] {
        CMD_FILL  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_STEP  = 2'd3
    } cmd_e_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BASE   = 3'd0,
        REG_LINE_PITCH   = 3'd1,
        REG_FOUR_BYTE    = 3'd2,
        REG_RED_SHIFT    = 3'd3,
        REG_GREEN_SHIFT  = 3'd4,
        REG_BLUE_SHIFT   = 3'd5,
        REG_SCREEN_WIDTH = 3'd6
    } reg_idx_t;

    // Register reset values
    localparam logic [31:0] FRAME_BASE_RST   = 32'd0;
    localparam logic [15:0] LINE_PITCH_RST   = 16'd5120;
    localparam logic        FOUR_BYTE_RST    = 1'b1;
    localparam logic [4:0]  RED_SHIFT_RST    = 5'd16;
    localparam logic [4:0]  GREEN_SHIFT_RST  = 5'd8;
    localparam logic [4:0]  BLUE_SHIFT_RST   = 5'd0;
    localparam logic [12:0] SCREEN_WIDTH_RST = 13'd1280;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] line_pitch;
        logic        four_byte_pixels;
        logic [4:0]  red_shift;
        logic [4:0]  green_shift;
        logic [4:0]  blue_shift;
        logic [12:0] screen_width;
    } cfg_t;

    typedef struct packed {
        cmd_e_t      command;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [12:0] rect_width;
        logic [12:0] rect_height;
        logic [23:0] color;
    } in_item_t;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic [2:0]  write_bytes;
        logic        last_write;
    } out_item_t;

endpackage

`default_nettype wire

// ===== design/frf_front.sv =====
// Front end: accepts commands, saturates sizes, packs the colour and forms
// the address products. Depends on frf_pkg.
`default_nettype none

module frf_front
    import frf_pkg::*;
#(
    parameter int MAX_COORD = MAX_COORD_DEF,
    parameter int CNT_W     = $clog2(MAX_COORD + 1),
    parameter int JOB_W     = JOB_FIXED_W + 2 * CNT_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_item,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output logic [JOB_W-1:0]      job
);

    typedef struct packed {
        logic              is_start;
        logic [PROD_W-1:0] prod;
        logic [XOFF_W-1:0] xoff;
        logic [31:0]       pixel;
        logic [CNT_W-1:0]  w;
        logic [CNT_W-1:0]  h;
    } job_t;

    logic  valid_reg, valid_next;
    job_t  job_reg, job_next;
    logic  accept;
    logic [11:0] x_sel;
    logic [7:0]  red, green, blue;

    function automatic logic [CNT_W-1:0] clamp_size(input logic [12:0] v);
        if (32'(v) > 32'(MAX_COORD))
            return CNT_W'(MAX_COORD);
        else
            return CNT_W'(v);
    endfunction

    // Hold the staged transaction while the queue is full
    assign in_stall  = valid_reg && !job_ready;
    assign accept    = in_valid && !in_stall;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    // Decode the command into a queue entry
    always_comb
    begin
        red   = in_item.color[23:16];
        green = in_item.color[15:8];
        blue  = in_item.color[7:0];
        x_sel = in_item.x_pos;
        job_next.is_start = (in_item.command != CMD_STEP);
        job_next.w = '0;
        job_next.h = '0;
        case (in_item.command)
            CMD_FILL:
            begin
                job_next.w = clamp_size(in_item.rect_width);
                job_next.h = clamp_size(in_item.rect_height);
            end
            CMD_PIXEL:
            begin
                job_next.w = CNT_W'(1);
                job_next.h = CNT_W'(1);
            end
            CMD_CLEAR:
            begin
                x_sel = '0;
                job_next.w = clamp_size(cfg.screen_width);
                job_next.h = clamp_size(in_item.rect_height);
            end
            default:
            begin
                job_next.w = '0;
                job_next.h = '0;
            end
        endcase
        job_next.prod = PROD_W'(in_item.y_pos) * PROD_W'(cfg.line_pitch);
        if (cfg.four_byte_pixels)
            job_next.xoff = {x_sel, 2'b00};
        else
            job_next.xoff = XOFF_W'({x_sel, 1'b0}) + XOFF_W'(x_sel);
        job_next.pixel = (32'(red) << cfg.red_shift) | (32'(green) << cfg.green_shift) |
                         (32'(blue) << cfg.blue_shift);
    end

    // Advance the stage
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (job_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

endmodule

`default_nettype wire

// ===== design/frf_queue.sv =====
// Short register queue between the front end and the write engine.
// Depends on frf_pkg for the default depth.
`default_nettype none

module frf_queue
    import frf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign ready     = (count_reg != CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && ready;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== design/frf_back.sv =====
// Write engine: loads fill state on start entries, issues one pixel write per
// step entry of an active fill into the output register. Depends on frf_pkg.
`default_nettype none

module frf_back
    import frf_pkg::*;
#(
    parameter int MAX_COORD = MAX_COORD_DEF,
    parameter int CNT_W     = $clog2(MAX_COORD + 1),
    parameter int JOB_W     = JOB_FIXED_W + 2 * CNT_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             job_valid,
    output logic                  job_pop,
    input  wire logic [JOB_W-1:0] job,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_item
);

    typedef struct packed {
        logic              is_start;
        logic [PROD_W-1:0] prod;
        logic [XOFF_W-1:0] xoff;
        logic [31:0]       pixel;
        logic [CNT_W-1:0]  w;
        logic [CNT_W-1:0]  h;
    } job_t;

    job_t job_in;

    logic             active_reg, active_next;
    logic [31:0]      row_addr_reg, row_addr_next;
    logic [31:0]      pix_addr_reg, pix_addr_next;
    logic [CNT_W-1:0] cols_reg, cols_next;
    logic [CNT_W-1:0] rows_reg, rows_next;
    logic [CNT_W-1:0] row_cols_reg, row_cols_next;
    logic [31:0]      packed_reg, packed_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic        out_free;
    logic [31:0] start_addr;
    logic [2:0]  bpp;

    assign job_in    = job_t'(job);
    assign out_free  = !out_valid_reg || !out_stall;
    assign job_pop   = job_valid && (job_in.is_start || !active_reg || out_free);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign bpp       = cfg.four_byte_pixels ? 3'd4 : 3'd3;
    assign start_addr = cfg.frame_base + 32'(job_in.prod) + 32'(job_in.xoff);

    // Load, step or hold the fill state
    always_comb
    begin
        active_next    = active_reg;
        row_addr_next  = row_addr_reg;
        pix_addr_next  = pix_addr_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        row_cols_next  = row_cols_reg;
        packed_next    = packed_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        if (job_pop)
        begin
            if (job_in.is_start)
            begin
                packed_next   = job_in.pixel;
                row_addr_next = start_addr;
                pix_addr_next = start_addr;
                row_cols_next = job_in.w;
                cols_next     = job_in.w;
                rows_next     = job_in.h;
                active_next   = (job_in.w != '0) && (job_in.h != '0);
            end
            else if (active_reg)
            begin
                out_valid_next = 1'b1;
                out_item_next.write_address = pix_addr_reg;
                out_item_next.write_data    = packed_reg;
                out_item_next.write_bytes   = bpp;
                out_item_next.last_write    = (cols_reg == CNT_W'(1)) &&
                                              (rows_reg == CNT_W'(1));
                cols_next = cols_reg - CNT_W'(1);
                if (cols_reg == CNT_W'(1))
                begin
                    rows_next = rows_reg - CNT_W'(1);
                    if (rows_reg == CNT_W'(1))
                        active_next = 1'b0;
                    else
                    begin
                        row_addr_next = row_addr_reg + 32'(cfg.line_pitch);
                        pix_addr_next = row_addr_reg + 32'(cfg.line_pitch);
                        cols_next     = row_cols_reg;
                    end
                end
                else
                    pix_addr_next = pix_addr_reg + 32'(bpp);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            row_addr_reg  <= '0;
            pix_addr_reg  <= '0;
            cols_reg      <= '0;
            rows_reg      <= '0;
            row_cols_reg  <= '0;
            packed_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            row_addr_reg  <= row_addr_next;
            pix_addr_reg  <= pix_addr_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            row_cols_reg  <= row_cols_next;
            packed_reg    <= packed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

// ===== design/framebuffer_rect_fill.sv =====
// Top level of the rectangle fill engine: configuration registers, front
// end, queue and write engine. Depends on frf_pkg, frf_front, frf_queue, frf_back.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    in_item   (in_item_t)
//   out       output     out_valid / out_stall  out_item  (out_item_t)
//   cfg       input      cfg_write              cfg_index, cfg_data
//
// One command is taken per cycle while the input is not stalled; each step
// command of an active fill yields one pixel write, issued by the single write
// engine that owns the fill counters. An accepted step passes the front stage
// register, a queue entry and the output register before its write appears.
// Reset clears the queue, the fill state and loads the register defaults. A
// stalled output holds active-fill steps back; the queue fills and the input stalls.
`default_nettype none

module framebuffer_rect_fill
    import frf_pkg::*;
#(
    parameter int MAX_COORD = MAX_COORD_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item
);

    localparam int CNT_W = $clog2(MAX_COORD + 1);
    localparam int JOB_W = JOB_FIXED_W + 2 * CNT_W;

    cfg_t cfg_reg, cfg_next;
    logic             f_valid, q_ready, q_valid, q_pop;
    logic [JOB_W-1:0] f_job, q_job;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FRAME_BASE:   cfg_next.frame_base       = cfg_data[31:0];
                REG_LINE_PITCH:   cfg_next.line_pitch       = cfg_data[15:0];
                REG_FOUR_BYTE:    cfg_next.four_byte_pixels = cfg_data[0];
                REG_RED_SHIFT:    cfg_next.red_shift        = cfg_data[4:0];
                REG_GREEN_SHIFT:  cfg_next.green_shift      = cfg_data[4:0];
                REG_BLUE_SHIFT:   cfg_next.blue_shift       = cfg_data[4:0];
                REG_SCREEN_WIDTH: cfg_next.screen_width     = cfg_data[12:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base       <= FRAME_BASE_RST;
            cfg_reg.line_pitch       <= LINE_PITCH_RST;
            cfg_reg.four_byte_pixels <= FOUR_BYTE_RST;
            cfg_reg.red_shift        <= RED_SHIFT_RST;
            cfg_reg.green_shift      <= GREEN_SHIFT_RST;
            cfg_reg.blue_shift       <= BLUE_SHIFT_RST;
            cfg_reg.screen_width     <= SCREEN_WIDTH_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    frf_front #(
        .MAX_COORD (MAX_COORD),
        .CNT_W     (CNT_W),
        .JOB_W     (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .job_valid (f_valid),
        .job_ready (q_ready),
        .job       (f_job)
    );

    frf_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .ready     (q_ready),
        .push_data (f_job),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_job)
    );

    frf_back #(
        .MAX_COORD (MAX_COORD),
        .CNT_W     (CNT_W),
        .JOB_W     (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (q_valid),
        .job_pop   (q_pop),
        .job       (q_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== bench/frf_checker.sv =====
// Checker for the rectangle fill engine: tracks register writes, predicts the pixel
// writes of each accepted command and compares them with the output channel.
// Depends on frf_pkg.
module frf_checker
    import frf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_item,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_item,
    output int                    mismatch_count,
    output int                    waiting_count
);

    // Shadow registers and fill state
    cfg_t        regs;
    logic        fill_on;
    logic [31:0] row_addr;
    logic [31:0] pix_addr;
    logic [31:0] pix_value;
    logic [12:0] cols_left;
    logic [12:0] rows_left;
    logic [12:0] row_cols;
    int          fails;

    out_item_t expected_writes[$];

    function automatic logic [12:0] clamp_size(logic [12:0] v);
        return (v > 13'(MAX_COORD_DEF)) ? 13'(MAX_COORD_DEF) : v;
    endfunction

    function automatic logic [2:0] pixel_bytes(cfg_t c);
        return c.four_byte_pixels ? 3'd4 : 3'd3;
    endfunction

    // Move each channel to its position; bits shifted past 31 are lost
    function automatic logic [31:0] pack_color(logic [23:0] rgb, cfg_t c);
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        r = {24'd0, rgb[23:16]};
        g = {24'd0, rgb[15:8]};
        b = {24'd0, rgb[7:0]};
        return (r << c.red_shift) | (g << c.green_shift) | (b << c.blue_shift);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            fails++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    task automatic check_write(input out_item_t got);
        out_item_t want;
        if (expected_writes.size() == 0)
        begin
            fails++;
            $display("%0t: pixel write expected none got %h", $time, got);
        end
        else
        begin
            want = expected_writes.pop_front();
            compare_field("write_address", want.write_address, got.write_address);
            compare_field("write_data", want.write_data, got.write_data);
            compare_field("write_bytes", 32'(want.write_bytes), 32'(got.write_bytes));
            compare_field("last_write", 32'(want.last_write), 32'(got.last_write));
        end
    endtask

    // Start a new rectangle, or emit one pixel write of the active one
    task automatic follow_command(input in_item_t t);
        logic [11:0] x;
        logic [12:0] w;
        logic [12:0] h;
        out_item_t   wr;
        if (t.command == CMD_STEP)
        begin
            if (fill_on)
            begin
                wr.write_address = pix_addr;
                wr.write_data    = pix_value;
                wr.write_bytes   = pixel_bytes(regs);
                wr.last_write    = (cols_left == 13'd1) && (rows_left == 13'd1);
                expected_writes.push_back(wr);
                cols_left = cols_left - 13'd1;
                if (cols_left == 13'd0)
                begin
                    rows_left = rows_left - 13'd1;
                    if (rows_left == 13'd0)
                    begin
                        fill_on = 1'b0;
                    end
                    else
                    begin
                        row_addr  = row_addr + {16'd0, regs.line_pitch};
                        pix_addr  = row_addr;
                        cols_left = row_cols;
                    end
                end
                else
                begin
                    pix_addr = pix_addr + 32'(pixel_bytes(regs));
                end
            end
        end
        else
        begin
            x = t.x_pos;
            case (t.command)
                CMD_FILL:
                begin
                    w = clamp_size(t.rect_width);
                    h = clamp_size(t.rect_height);
                end
                CMD_PIXEL:
                begin
                    w = 13'd1;
                    h = 13'd1;
                end
                default:
                begin
                    x = 12'd0;
                    w = clamp_size(regs.screen_width);
                    h = clamp_size(t.rect_height);
                end
            endcase
            pix_value = pack_color(t.color, regs);
            row_addr  = regs.frame_base + 32'(t.y_pos) * 32'(regs.line_pitch)
                        + 32'(x) * 32'(pixel_bytes(regs));
            pix_addr  = row_addr;
            row_cols  = w;
            cols_left = w;
            rows_left = h;
            fill_on   = (w != 13'd0) && (h != 13'd0);
        end
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_BASE:   regs.frame_base       = data;
            REG_LINE_PITCH:   regs.line_pitch       = data[15:0];
            REG_FOUR_BYTE:    regs.four_byte_pixels = data[0];
            REG_RED_SHIFT:    regs.red_shift        = data[4:0];
            REG_GREEN_SHIFT:  regs.green_shift      = data[4:0];
            REG_BLUE_SHIFT:   regs.blue_shift       = data[4:0];
            REG_SCREEN_WIDTH: regs.screen_width     = data[12:0];
            default: ;
        endcase
    endtask

    // Compare outputs first: a command accepted on this edge has no write out yet
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.frame_base       = FRAME_BASE_RST;
            regs.line_pitch       = LINE_PITCH_RST;
            regs.four_byte_pixels = FOUR_BYTE_RST;
            regs.red_shift        = RED_SHIFT_RST;
            regs.green_shift      = GREEN_SHIFT_RST;
            regs.blue_shift       = BLUE_SHIFT_RST;
            regs.screen_width     = SCREEN_WIDTH_RST;
            fill_on   = 1'b0;
            row_addr  = '0;
            pix_addr  = '0;
            pix_value = '0;
            cols_left = '0;
            rows_left = '0;
            row_cols  = '0;
            fails     = 0;
            expected_writes.delete();
            mismatch_count <= 0;
            waiting_count  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_write(out_item);
            if (in_valid && !in_stall)
                follow_command(in_item);
            if (cfg_write)
                load_register(cfg_index, cfg_data);
            mismatch_count <= fails;
            waiting_count  <= expected_writes.size();
        end
    end

endmodule

// ===== bench/framebuffer_rect_fill_test.sv =====
// Top of the rectangle fill engine bench: clock, reset, register phases and
// command stimulus with random idling. Depends on frf_pkg, frf_checker and the block.
module framebuffer_rect_fill_test;
    import frf_pkg::*;

    localparam int RANDOM_ITEMS   = 1520;
    localparam int PHASES         = 8;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_BASE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    in_item_t              in_item   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    out_item_t             out_item;

    int          mismatch_count;
    int          waiting_count;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    bit          busy_mode   = 1'b1;
    logic [12:0] screen_cols = SCREEN_WIDTH_RST;

    always #2 clk = ~clk;

    framebuffer_rect_fill dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    frf_checker check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .mismatch_count (mismatch_count),
        .waiting_count  (waiting_count)
    );

    // Stall the write side at random outside the quiet stretch
    always @(posedge clk)
        out_stall <= busy_mode && ($urandom_range(99) < 30);

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic in_item_t make_cmd(cmd_e_t c, logic [11:0] x, logic [11:0] y,
                                          logic [12:0] w, logic [12:0] h,
                                          logic [23:0] rgb);
        in_item_t t;
        t.command     = c;
        t.x_pos       = x;
        t.y_pos       = y;
        t.rect_width  = w;
        t.rect_height = h;
        t.color       = rgb;
        return t;
    endfunction

    function automatic in_item_t random_item();
        return make_cmd(cmd_e_t'($urandom_range(CMD_STEP)), 12'($urandom), 12'($urandom),
                        13'($urandom), 13'($urandom), 24'($urandom));
    endfunction

    function automatic in_item_t step_item();
        in_item_t t;
        t = random_item();
        t.command = CMD_STEP;
        return t;
    endfunction

    // Pixels a start command will produce, sizes saturated as the block does
    function automatic int pixels_in(in_item_t t);
        int w;
        int h;
        case (t.command)
            CMD_FILL:
            begin
                w = t.rect_width;
                h = t.rect_height;
            end
            CMD_PIXEL:
            begin
                w = 1;
                h = 1;
            end
            default:
            begin
                w = screen_cols;
                h = t.rect_height;
            end
        endcase
        if (w > MAX_COORD_DEF)
            w = MAX_COORD_DEF;
        if (h > MAX_COORD_DEF)
            h = MAX_COORD_DEF;
        return w * h;
    endfunction

    // Drive one command transaction and hold it until accepted
    task automatic send(input in_item_t t);
        while (busy_mode && ($urandom_range(99) < 30))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_steps(input int n);
        repeat (n)
            send(step_item());
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Drain every expected write, let the pipeline settle, then load all registers
    task automatic reconfigure(input cfg_t c);
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        cfg_write <= 1'b1;
        set_reg(REG_FRAME_BASE, c.frame_base);
        set_reg(REG_LINE_PITCH, 32'(c.line_pitch));
        set_reg(REG_FOUR_BYTE, 32'(c.four_byte_pixels));
        set_reg(REG_RED_SHIFT, 32'(c.red_shift));
        set_reg(REG_GREEN_SHIFT, 32'(c.green_shift));
        set_reg(REG_BLUE_SHIFT, 32'(c.blue_shift));
        set_reg(REG_SCREEN_WIDTH, 32'(c.screen_width));
        cfg_write   <= 1'b0;
        screen_cols = c.screen_width;
    endtask

    function automatic cfg_t phase_config(int phase);
        cfg_t c;
        c.frame_base       = $urandom;
        c.line_pitch       = 16'($urandom);
        c.four_byte_pixels = 1'($urandom);
        c.red_shift        = 5'($urandom);
        c.green_shift      = 5'($urandom);
        c.blue_shift       = 5'($urandom);
        c.screen_width     = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(8));
        if (phase == 0)
            c = '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 5'd31, 5'd31, 5'd31, 13'h1FFF};
        else if (phase == 1)
            c = '0;
        return c;
    endfunction

    // Mostly start-then-step sequences with random content, some noise mixed in
    task automatic random_burst(input int target);
        in_item_t t;
        int       steps;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                send(random_item());
            end
            else
            begin
                t = random_item();
                t.command     = cmd_e_t'($urandom_range(CMD_CLEAR));
                t.rect_width  = ($urandom_range(19) == 0) ? 13'($urandom)
                                                          : 13'($urandom_range(6));
                t.rect_height = ($urandom_range(19) == 0) ? 13'($urandom)
                                                          : 13'($urandom_range(4));
                send(t);
                steps = pixels_in(t);
                if (steps > 40)
                    steps = $urandom_range(1, 20);
                else if ($urandom_range(5) == 0)
                    steps = $urandom_range(steps);
                else if ($urandom_range(3) == 0)
                    steps++;
                send_steps(steps);
            end
        end
    endtask

    initial
    begin
        int start_count;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle step, corner rectangle, black pixel, empty rectangles,
        // oversize fill replaced by a new start
        send(step_item());
        send(make_cmd(CMD_FILL, 12'hFFF, 12'hFFF, 13'd2, 13'd2, 24'hFFFFFF));
        send_steps(4);
        send(make_cmd(CMD_PIXEL, 12'd0, 12'd0, 13'd0, 13'd0, 24'h000000));
        send_steps(1);
        send(make_cmd(CMD_FILL, 12'd5, 12'd6, 13'd0, 13'd3, 24'h00FF00));
        send_steps(1);
        send(make_cmd(CMD_FILL, 12'd5, 12'd6, 13'd3, 13'd0, 24'hFF0000));
        send_steps(1);
        send(make_cmd(CMD_FILL, 12'd1, 12'd2, 13'h1FFF, 13'h1FFF, 24'hA5C3E1));
        send_steps(3);
        send(make_cmd(CMD_PIXEL, 12'd7, 12'd9, 13'd0, 13'd0, 24'h5A3C1E));
        send_steps(2);

        // Directed: clear rows with 3-byte pixels, large shifts and address wrap
        reconfigure('{32'hFFFF_FFF0, 16'hFFFF, 1'b0, 5'd24, 5'd31, 5'd7, 13'd3});
        send(make_cmd(CMD_CLEAR, 12'd123, 12'hFFF, 13'd0, 13'd2, 24'hFFFFFF));
        send_steps(6);

        // Random phases, each under its own register setting; one runs without idling
        start_count = items_sent;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            reconfigure(phase_config(phase));
            busy_mode = (phase != 3);
            random_burst(start_count + (phase + 1) * RANDOM_ITEMS / PHASES);
        end
        busy_mode = 1'b1;

        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && waiting_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
design/frf_pkg.sv
design/frf_front.sv
design/frf_queue.sv
design/frf_back.sv
design/framebuffer_rect_fill.sv
bench/frf_checker.sv
bench/framebuffer_rect_fill_test.sv
